// ===== rtl/haaz_pkg.sv =====
// haaz_pkg: types, constants and arctangent table for the hour angle to
// altitude/azimuth converter. No dependencies.
package haaz_pkg;

   localparam int          VEC_W    = 36;
   localparam int          ANG_W    = 32;
   localparam logic signed [VEC_W-1:0] GAIN_Q30 = 36'sd652032874;
   localparam logic signed [VEC_W-1:0] POLE_TOL = 36'sd64;
   localparam logic signed [ANG_W-1:0] QUARTER  = 32'sh4000_0000;
   localparam logic signed [ANG_W-1:0] NEG_QUARTER = 32'shC000_0000;
   localparam logic        [ANG_W-1:0] HALF_TURN = 32'h8000_0000;

   typedef logic signed [VEC_W-1:0] vec_type;
   typedef logic signed [ANG_W-1:0] ang_type;

   // rotation mode drives z to zero, vectoring mode drives y to zero
   typedef enum logic {
      MODE_ROTATE = 1'b0,
      MODE_VECTOR = 1'b1
   } mode_type;

   typedef struct packed {
      vec_type x;
      vec_type y;
      ang_type z;
   } cvec_type;

   function automatic ang_type atan_angle(input int idx);
      logic [31:0] t;
      case (idx)
         0: t = 32'h20000000;   1: t = 32'h12E4051E;   2: t = 32'h09FB385B;
         3: t = 32'h051111D4;   4: t = 32'h028B0D43;   5: t = 32'h0145D7E1;
         6: t = 32'h00A2F61E;   7: t = 32'h00517C55;   8: t = 32'h0028BE53;
         9: t = 32'h00145F2F;   10: t = 32'h000A2F98;  11: t = 32'h000517CC;
         12: t = 32'h00028BE6;  13: t = 32'h000145F3;  14: t = 32'h0000A2FA;
         15: t = 32'h0000517D;  16: t = 32'h000028BE;  17: t = 32'h0000145F;
         18: t = 32'h00000A30;  19: t = 32'h00000518;  20: t = 32'h0000028C;
         21: t = 32'h00000146;  22: t = 32'h000000A3;  23: t = 32'h00000051;
         24: t = 32'h00000029;  25: t = 32'h00000014;  26: t = 32'h0000000A;
         27: t = 32'h00000005;  28: t = 32'h00000003;  29: t = 32'h00000001;
         30: t = 32'h00000001;
         default: t = 32'h00000000;
      endcase
      return ang_type'(t);
   endfunction

endpackage

// ===== rtl/haaz_cell.sv =====
// haaz_cell: one registered cordic micro-rotation, rotation or vectoring.
// Depends on haaz_pkg.
module haaz_cell #(
   parameter int STAGE = 0,
   parameter bit VECTOR = 1'b0
) (
   input  logic                clock,
   input  logic                enable,
   input  haaz_pkg::cvec_type  vec_in,
   output haaz_pkg::cvec_type  vec_out
);
   import haaz_pkg::*;

   localparam ang_type ATAN = atan_angle(STAGE);

   cvec_type cell_in, cell_ff;
   vec_type  dx, dy;
   logic     go_pos;

   // arithmetic shifts floor toward minus infinity
   assign dx = vec_in.y >>> STAGE;
   assign dy = vec_in.x >>> STAGE;
   assign go_pos = (VECTOR == MODE_VECTOR) ? !vec_in.y[VEC_W-1] : !vec_in.z[ANG_W-1];

   // micro-rotation
   always_comb begin
      if (VECTOR == MODE_VECTOR) begin
         if (go_pos) begin
            cell_in.x = vec_in.x + dx;
            cell_in.y = vec_in.y - dy;
            cell_in.z = vec_in.z + ATAN;
         end else begin
            cell_in.x = vec_in.x - dx;
            cell_in.y = vec_in.y + dy;
            cell_in.z = vec_in.z - ATAN;
         end
      end else begin
         if (go_pos) begin
            cell_in.x = vec_in.x - dx;
            cell_in.y = vec_in.y + dy;
            cell_in.z = vec_in.z - ATAN;
         end else begin
            cell_in.x = vec_in.x + dx;
            cell_in.y = vec_in.y - dy;
            cell_in.z = vec_in.z + ATAN;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         cell_ff <= cell_in;
      end
   end

   assign vec_out = cell_ff;
endmodule

// ===== rtl/haaz_chain.sv =====
// haaz_chain: row of cordic cells with a side band of sideinfo bits moved in step.
// Depends on haaz_pkg and haaz_cell.
module haaz_chain #(
   parameter int STAGES = 30,
   parameter bit VECTOR = 1'b0,
   parameter int SIDE_W = 1
) (
   input  logic                clock,
   input  logic                enable,
   input  haaz_pkg::cvec_type  vec_in,
   input  logic [SIDE_W-1:0]   side_in,
   output haaz_pkg::cvec_type  vec_out,
   output logic [SIDE_W-1:0]   side_out
);
   import haaz_pkg::*;

   cvec_type          taps [STAGES+1];
   logic [SIDE_W-1:0] side_ff [STAGES];

   assign taps[0] = vec_in;

   // cell row
   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      haaz_cell #(.STAGE(i), .VECTOR(VECTOR)) u_cell (
         .clock  (clock),
         .enable (enable),
         .vec_in (taps[i]),
         .vec_out(taps[i+1])
      );
   end

   // side band moves one stage per enabled cycle beside the cells
   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   assign vec_out  = taps[STAGES];
   assign side_out = side_ff[STAGES-1];
endmodule

// ===== rtl/hour_angle_to_alt_azimuth_top.sv =====
// hour_angle_to_alt_azimuth_top: equatorial to horizontal conversion pipeline.
// Depends on haaz_pkg and haaz_chain.
// Throughput: one transaction per cycle; the whole pipeline advances on one
// shared enable, so a stalled response holds every stage.
// Reset: synchronous; clears valid bits and the latitude register to zero.
module hour_angle_to_alt_azimuth_top #(
   parameter int CORDIC_STAGES = 30
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic signed [31:0]      csr_write_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic signed [31:0]      req_hour_angle,
   input  logic signed [31:0]      req_declination,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [31:0]      rsp_azimuth,
   output logic signed [31:0]      rsp_altitude,
   output logic                    rsp_at_pole
);
   import haaz_pkg::*;

   localparam int S = CORDIC_STAGES;
   // fold 1 + sincos S + products 2 + az prep 1 + atan S + gain 1 + alt prep 1
   // + atan S + out 1 = 3S + 7
   localparam int DEPTH = 3 * S + 7;

   ang_type lat_ff;
   logic    adv;
   logic [DEPTH-1:0] vld_ff;

   // the pipeline moves whenever the last stage is empty or being taken
   assign adv       = !rsp_valid || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_ff <= '0;
      end else if (csr_write_enable) begin
         lat_ff <= csr_write_data;
      end
   end

   // valid shift line
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end
   assign rsp_valid = vld_ff[DEPTH-1];

   // stage 0: quadrant folding for the three sine/cosine chains
   function automatic cvec_type fold(input ang_type a, output logic neg);
      cvec_type v;
      neg = (a > QUARTER) || (a < NEG_QUARTER);
      v.x = GAIN_Q30;
      v.y = '0;
      v.z = neg ? ang_type'(a + HALF_TURN) : a;
      return v;
   endfunction

   cvec_type f_in [3], f_ff [3], sc_out [3];
   logic     n_in [3];
   logic     n_ff [3];
   logic [2:0] n_out;

   always_comb begin
      f_in[0] = fold(lat_ff, n_in[0]);
      f_in[1] = fold(req_hour_angle, n_in[1]);
      f_in[2] = fold(req_declination, n_in[2]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff <= f_in;
         n_ff <= n_in;
      end
   end

   for (genvar k = 0; k < 3; k++) begin : g_sc
      logic side_o;
      haaz_chain #(.STAGES(S), .VECTOR(MODE_ROTATE), .SIDE_W(1)) u_sc (
         .clock   (clock),
         .enable  (adv),
         .vec_in  (f_ff[k]),
         .side_in (n_ff[k]),
         .vec_out (sc_out[k]),
         .side_out(side_o)
      );
      assign n_out[k] = side_o;
   end

   // sine/cosine with the half-turn sign restored
   vec_type cl, sl, ch, sh, cd, sd;
   assign cl = n_out[0] ? -sc_out[0].x : sc_out[0].x;
   assign sl = n_out[0] ? -sc_out[0].y : sc_out[0].y;
   assign ch = n_out[1] ? -sc_out[1].x : sc_out[1].x;
   assign sh = n_out[1] ? -sc_out[1].y : sc_out[1].y;
   assign cd = n_out[2] ? -sc_out[2].x : sc_out[2].x;
   assign sd = n_out[2] ? -sc_out[2].y : sc_out[2].y;

   // product stage a: cdch, sh*cd, sl*sd, cl*sd
   logic signed [71:0] p_cdch, p_yn, p_slsd, p_clsd;
   vec_type m1_cdch_ff, m1_yn_ff, m1_sl_ff, m1_cl_ff;
   logic signed [71:0] m1_slsd_ff, m1_clsd_ff;
   assign p_cdch = 72'(cd) * 72'(ch);
   assign p_yn   = 72'(sh) * 72'(cd);
   assign p_slsd = 72'(sl) * 72'(sd);
   assign p_clsd = 72'(cl) * 72'(sd);

   always_ff @(posedge clock) begin
      if (adv) begin
         m1_cdch_ff <= vec_type'(p_cdch >>> 30);
         m1_yn_ff   <= vec_type'(p_yn >>> 30);
         m1_sl_ff   <= sl;
         m1_cl_ff   <= cl;
         m1_slsd_ff <= p_slsd;
         m1_clsd_ff <= p_clsd;
      end
   end

   // product stage b: terms with cdch
   logic signed [71:0] m2_zc_in, m2_xn_in;
   vec_type zc_ff, xn_ff, yn_ff;
   assign m2_zc_in = m1_slsd_ff + 72'(m1_cl_ff) * 72'(m1_cdch_ff);
   assign m2_xn_in = 72'(m1_sl_ff) * 72'(m1_cdch_ff) - m1_clsd_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         zc_ff <= vec_type'(m2_zc_in >>> 30);
         xn_ff <= vec_type'(m2_xn_in >>> 30);
         yn_ff <= m1_yn_ff;
      end
   end

   // pole test and azimuth vector prep
   logic    pole_c, mer_c;
   cvec_type az_v_in, az_v_ff;
   typedef struct packed {
      logic    pole;
      logic    mer;
      vec_type xn;
      vec_type zc;
   } az_side_type;
   az_side_type az_s_in, az_s_ff, az_s_out;

   assign pole_c = (xn_ff < POLE_TOL) && (xn_ff > -POLE_TOL) &&
                   (yn_ff < POLE_TOL) && (yn_ff > -POLE_TOL);
   assign mer_c  = (yn_ff == '0);

   always_comb begin
      if (xn_ff[VEC_W-1]) begin
         az_v_in.x = -xn_ff;
         az_v_in.y = -yn_ff;
         az_v_in.z = HALF_TURN;
      end else begin
         az_v_in.x = xn_ff;
         az_v_in.y = yn_ff;
         az_v_in.z = '0;
      end
      az_s_in.pole = pole_c;
      az_s_in.mer  = mer_c;
      az_s_in.xn   = xn_ff;
      az_s_in.zc   = zc_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         az_v_ff <= az_v_in;
         az_s_ff <= az_s_in;
      end
   end

   cvec_type az_out;
   haaz_chain #(.STAGES(S), .VECTOR(MODE_VECTOR), .SIDE_W($bits(az_side_type))) u_az (
      .clock   (clock),
      .enable  (adv),
      .vec_in  (az_v_ff),
      .side_in (az_s_ff),
      .vec_out (az_out),
      .side_out(az_s_out)
   );

   // gain scaling of the horizontal magnitude; on the meridian |xn| is taken unscaled
   logic signed [71:0] g_prod;
   vec_type r_ff, zc2_ff;
   ang_type az_ff;
   logic    pole2_ff;
   vec_type mag_abs;
   assign g_prod  = 72'(az_out.x) * 72'(GAIN_Q30);
   assign mag_abs = az_s_out.xn[VEC_W-1] ? -az_s_out.xn : az_s_out.xn;

   always_ff @(posedge clock) begin
      if (adv) begin
         if (az_s_out.mer) begin
            r_ff  <= mag_abs;
            az_ff <= az_s_out.xn[VEC_W-1] ? HALF_TURN : '0;
         end else begin
            r_ff  <= vec_type'(g_prod >>> 30);
            az_ff <= az_out.z;
         end
         zc2_ff   <= az_s_out.zc;
         pole2_ff <= az_s_out.pole;
      end
   end

   // altitude vector prep
   cvec_type al_v_in, al_v_ff;
   typedef struct packed {
      logic    pole;
      logic    zneg;
      ang_type az;
   } al_side_type;
   al_side_type al_s_in, al_s_ff, al_s_out;

   always_comb begin
      if (r_ff[VEC_W-1]) begin
         al_v_in.x = -r_ff;
         al_v_in.y = -zc2_ff;
         al_v_in.z = HALF_TURN;
      end else begin
         al_v_in.x = r_ff;
         al_v_in.y = zc2_ff;
         al_v_in.z = '0;
      end
      al_s_in.pole = pole2_ff;
      al_s_in.zneg = zc2_ff[VEC_W-1];
      al_s_in.az   = az_ff;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         al_v_ff <= al_v_in;
         al_s_ff <= al_s_in;
      end
   end

   cvec_type al_out;
   haaz_chain #(.STAGES(S), .VECTOR(MODE_VECTOR), .SIDE_W($bits(al_side_type))) u_al (
      .clock   (clock),
      .enable  (adv),
      .vec_in  (al_v_ff),
      .side_in (al_s_ff),
      .vec_out (al_out),
      .side_out(al_s_out)
   );

   // output register
   ang_type out_az_ff, out_alt_ff;
   logic    out_pole_ff;
   always_ff @(posedge clock) begin
      if (adv) begin
         out_pole_ff <= al_s_out.pole;
         if (al_s_out.pole) begin
            out_az_ff  <= '0;
            out_alt_ff <= al_s_out.zneg ? NEG_QUARTER : QUARTER;
         end else begin
            out_az_ff  <= al_s_out.az;
            out_alt_ff <= al_out.z;
         end
      end
   end

   assign rsp_azimuth  = out_az_ff;
   assign rsp_altitude = out_alt_ff;
   assign rsp_at_pole  = out_pole_ff;

   // pipeline checks
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_azimuth))
      else $error("response changed under stall");
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("request stall mismatch");
   a_pole_az: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_at_pole |-> rsp_azimuth == '0)
      else $error("pole response with nonzero azimuth");
endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for hour_angle_to_alt_azimuth_top.
// Depends on haaz_pkg and the converter RTL; predicts every response with a
// cycle-free CORDIC model and checks responses in order.
module testbench;
   import haaz_pkg::*;

   localparam int STAGES     = 30;
   localparam int LATENCY    = 3*STAGES + 8;
   localparam int WDOG_LIMIT = 4000;
   localparam int N_RANDOM   = 1900;
   localparam int N_PHASES   = 6;
   localparam logic signed [31:0] LAT_MIN = -32'sd1073741824;
   localparam logic signed [31:0] LAT_MAX = 32'sd1073741824;

   localparam bit [31:0] ARCTAN_TAB [0:31] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
      32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F,
      32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
      32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
      32'h00000001, 32'h00000000
   };

   typedef struct {
      logic signed [31:0] azimuth;
      logic signed [31:0] altitude;
      logic               at_pole;
   } horiz_coord_type;

   // scoreboard: predicts horizontal coordinates and checks them in order
   class horiz_scoreboard;
      horiz_coord_type    pending_coords[$];
      logic signed [31:0] latitude;
      int                 mismatches;
      int                 accepted;

      function new();
         latitude   = '0;
         mismatches = 0;
         accepted   = 0;
      endfunction

      function void sin_cos(input logic [31:0] ang, output longint c, output longint s);
         longint x, y, z, dx, dy;
         bit     flip;
         x = longint'(GAIN_Q30);
         y = 0;
         z = longint'(signed'(ang));
         flip = 1'b0;
         if (z > longint'(QUARTER) || z < -longint'(QUARTER)) begin
            z = longint'(signed'(ang + HALF_TURN));
            flip = 1'b1;
         end
         for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x = x - dx; y = y + dy; z = z - longint'(ARCTAN_TAB[i]);
            end else begin
               x = x + dx; y = y - dy; z = z + longint'(ARCTAN_TAB[i]);
            end
         end
         c = flip ? -x : x;
         s = flip ? -y : y;
      endfunction

      function logic [31:0] vector_angle(input longint x0, input longint y0,
                                         output longint mag);
         longint      x, y, dx, dy;
         logic [31:0] z;
         x = x0;
         y = y0;
         z = '0;
         if (x < 0) begin
            x = -x; y = -y; z = HALF_TURN;
         end
         for (int i = 0; i < STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y < 0) begin
               x = x - dx; y = y + dy; z = z - ARCTAN_TAB[i];
            end else begin
               x = x + dx; y = y - dy; z = z + ARCTAN_TAB[i];
            end
         end
         mag = x;
         return z;
      endfunction

      function horiz_coord_type convert(input logic signed [31:0] ha,
                                        input logic signed [31:0] dec);
         horiz_coord_type res;
         longint cl, sl, ch, sh, cd, sd, cdch, vert, hx, hy, mag, rad, tol;
         sin_cos(latitude, cl, sl);
         sin_cos(ha, ch, sh);
         sin_cos(dec, cd, sd);
         cdch = (cd * ch) >>> 30;
         vert = (sl * sd + cl * cdch) >>> 30;
         hx   = (sl * cdch - cl * sd) >>> 30;
         hy   = (sh * cd) >>> 30;
         tol  = longint'(POLE_TOL);
         res.at_pole = (hx < tol && hx > -tol && hy < tol && hy > -tol);
         // zenith or nadir: no defined azimuth
         if (res.at_pole) begin
            res.azimuth  = '0;
            res.altitude = (vert >= 0) ? QUARTER : NEG_QUARTER;
         end else begin
            // object on the meridian needs no azimuth vectoring pass
            if (hy == 0) begin
               res.azimuth = (hx >= 0) ? '0 : HALF_TURN;
               rad = (hx >= 0) ? hx : -hx;
            end else begin
               res.azimuth = vector_angle(hx, hy, mag);
               rad = (mag * longint'(GAIN_Q30)) >>> 30;
            end
            res.altitude = vector_angle(rad, vert, mag);
         end
         return res;
      endfunction

      function void note_request(input logic signed [31:0] ha, input logic signed [31:0] dec);
         pending_coords.push_back(convert(ha, dec));
         accepted++;
      endfunction

      function void check_response(input logic signed [31:0] az, input logic signed [31:0] alt,
                                   input logic pole);
         horiz_coord_type exp_c;
         if (pending_coords.size() == 0) begin
            $error("response with no request outstanding");
            mismatches++;
            return;
         end
         exp_c = pending_coords.pop_front();
         if (az !== exp_c.azimuth) begin
            $error("azimuth expected %0d actual %0d", exp_c.azimuth, az);
            mismatches++;
         end
         if (alt !== exp_c.altitude) begin
            $error("altitude expected %0d actual %0d", exp_c.altitude, alt);
            mismatches++;
         end
         if (pole !== exp_c.at_pole) begin
            $error("at_pole expected %0b actual %0b", exp_c.at_pole, pole);
            mismatches++;
         end
      endfunction
   endclass

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic signed [31:0] csr_write_data = '0;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic signed [31:0] req_hour_angle = '0;
   logic signed [31:0] req_declination = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b1;
   logic signed [31:0] rsp_azimuth;
   logic signed [31:0] rsp_altitude;
   logic               rsp_at_pole;

   int  tx_idle_pct = 0;
   int  rx_idle_pct = 0;
   int  hold_left = 0;
   bit  hold_done = 1'b0;
   int  quiet_cycles = 0;
   horiz_scoreboard sb = new();

   hour_angle_to_alt_azimuth_top #(.CORDIC_STAGES(STAGES)) u_top (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_write_data  (csr_write_data),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_hour_angle  (req_hour_angle),
      .req_declination (req_declination),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_azimuth     (rsp_azimuth),
      .rsp_altitude    (rsp_altitude),
      .rsp_at_pole     (rsp_at_pole)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // receiver stall, with one long hold-off once 400 requests have been accepted
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && sb.accepted >= 400) begin
         rsp_stall <= 1'b1;
         hold_left <= 300;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
   end

   // transaction monitors and latitude shadow
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_write_enable)
            sb.latitude = csr_write_data;
         if (req_valid && !req_stall)
            sb.note_request(req_hour_angle, req_declination);
         if (rsp_valid && !rsp_stall)
            sb.check_response(rsp_azimuth, rsp_altitude, rsp_at_pole);
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
         $display("hour_angle_to_alt_azimuth_top verification failed");
         $finish;
      end
   end

   task automatic send_coord(input logic signed [31:0] ha, input logic signed [31:0] dec);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_hour_angle  <= ha;
      req_declination <= dec;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
   endtask

   task automatic write_latitude(input logic signed [31:0] lat);
      req_valid        <= 1'b0;
      csr_write_enable <= 1'b1;
      csr_write_data   <= lat;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic drain_pipe();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_coords.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_dec();
      return 32'(longint'($urandom_range(0, 32'h8000_0000)) - 64'sd1073741824);
   endfunction

   task automatic send_random(input logic signed [31:0] lat);
      logic signed [31:0] ha, dec;
      int                 kind;
      kind = $urandom_range(0, 9);
      ha   = $urandom;
      dec  = rand_dec();
      case (kind)
         // near zenith (hour angle zero) or on the lower meridian, at a celestial pole, or on the meridian
         0: begin
            dec = lat + $signed($urandom_range(0, 8)) - 4;
            ha  = $urandom_range(0, 1) ? 32'sh0 : 32'sh8000_0000;
         end
         1: dec = $urandom_range(0, 1) ? LAT_MAX : LAT_MIN;
         2: ha = $urandom_range(0, 1) ? 32'sh0 : 32'sh8000_0000;
         default: ;
      endcase
      send_coord(ha, dec);
   endtask

   // stimulus
   initial begin
      logic signed [31:0] lat_set [N_PHASES];
      lat_set[0] = '0;
      lat_set[1] = LAT_MIN;
      lat_set[2] = LAT_MAX;
      lat_set[3] = rand_dec();
      lat_set[4] = rand_dec();
      lat_set[5] = 32'sh2AAA_AAAB;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners at zero latitude
      write_latitude(lat_set[0]);
      send_coord(32'sh0, 32'sh0);
      send_coord(32'sh8000_0000, 32'sh0);
      send_coord(32'sh7FFF_FFFF, 32'sh0);
      send_coord(32'sh4000_0000, 32'sh0);
      send_coord(-32'sh4000_0000, 32'sh0);
      send_coord(32'sh0, LAT_MAX);
      send_coord(32'sh0, LAT_MIN);
      send_coord(32'sh1234_5678, LAT_MAX);
      send_coord(32'sh8000_0000, LAT_MIN);
      send_coord(32'sh7FFF_FFFF, LAT_MAX);
      send_coord(32'sh8000_0000, LAT_MAX - 1);
      send_coord(32'sh0, 32'sh2000_0000);
      send_coord(32'sh8000_0000, -32'sh2000_0000);
      send_coord(32'sh4000_0001, 32'sh1000_0000);
      send_coord(-32'sh4000_0001, -32'sh1000_0000);
      send_coord(32'sh0000_0001, 32'shFFFF_FFFF);
      send_coord(32'shFFFF_FFFF, 32'sh0000_0001);
      send_coord(32'sh5555_5555, 32'sh2AAA_AAAA);
      send_coord(32'shAAAA_AAAA, 32'shD555_5556);
      drain_pipe();

      // random phases across latitudes and idle patterns
      for (int p = 0; p < N_PHASES; p++) begin
         case (p % 3)
            0: begin tx_idle_pct = 24; rx_idle_pct = 47; end
            1: begin tx_idle_pct = 47; rx_idle_pct = 24; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         if (p > 0)
            write_latitude(lat_set[p]);
         send_coord(32'sh0, lat_set[p]);
         for (int n = 0; n < N_RANDOM / N_PHASES; n++)
            send_random(lat_set[p]);
         drain_pipe();
      end

      if (sb.mismatches == 0) begin
         $display("hour_angle_to_alt_azimuth_top verification clean");
      end else begin
         $display("hour_angle_to_alt_azimuth_top verification failed");
      end
      $finish;
   end

endmodule
